>>> rtl/integer_to_crockford_text_macros.svh
// ----------------------------------------------------------------------------
// Integer to Crockford text: assertion macros
// Shared property wrappers for the block's checker.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_CROCKFORD_TEXT_MACROS_SVH
`define INTEGER_TO_CROCKFORD_TEXT_MACROS_SVH

// same-cycle implication, disabled in reset
`define I2CT_ASSERT_SAME(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define I2CT_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/i2ct_pkg.sv
// ----------------------------------------------------------------------------
// Integer to Crockford text: package
// Constants shared by the block and its checker, and the digit alphabet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2ct_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int RADIX_BITS         = 6;
  localparam int DIGIT_BITS         = 5;
  localparam int CHAR_BITS          = 7;
  localparam int DIV_STEP           = 8;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd32;

  localparam logic [CHAR_BITS-1:0] MINUS_CODE = 7'd45;

  function automatic logic [CHAR_BITS-1:0] crockford_char(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    unique case (d)
      5'd0:  c = 7'h30;
      5'd1:  c = 7'h31;
      5'd2:  c = 7'h32;
      5'd3:  c = 7'h33;
      5'd4:  c = 7'h34;
      5'd5:  c = 7'h35;
      5'd6:  c = 7'h36;
      5'd7:  c = 7'h37;
      5'd8:  c = 7'h38;
      5'd9:  c = 7'h39;
      5'd10: c = 7'h61;
      5'd11: c = 7'h62;
      5'd12: c = 7'h63;
      5'd13: c = 7'h64;
      5'd14: c = 7'h65;
      5'd15: c = 7'h66;
      5'd16: c = 7'h67;
      5'd17: c = 7'h68;
      5'd18: c = 7'h6a;
      5'd19: c = 7'h6b;
      5'd20: c = 7'h6d;
      5'd21: c = 7'h6e;
      5'd22: c = 7'h70;
      5'd23: c = 7'h71;
      5'd24: c = 7'h72;
      5'd25: c = 7'h73;
      5'd26: c = 7'h74;
      5'd27: c = 7'h76;
      5'd28: c = 7'h77;
      5'd29: c = 7'h78;
      5'd30: c = 7'h79;
      default: c = 7'h7a;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/integer_to_crockford_text.sv
// ----------------------------------------------------------------------------
// Integer to Crockford text
// Writes a signed integer as lowercase Crockford text in base 2 to 32.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one signed value per request (low VALUE_BITS bits, sign
//   extended). m_* returns its text one ASCII character per request: a '-'
//   for negative values, then the digits most significant first; tlast marks
//   the final character. With radix outside 2..32 a single request with
//   tuser = 1, tdata = 0 and tlast = 1 is returned instead.
//   cfg_* writes the radix; write it only while the block is idle.
// Timing:
//   One shared restoring divider retires DIV_STEP quotient bits per cycle.
//   Each value is first divided digit by digit, then its characters are
//   sent as m_tready accepts them, and then the block is idle again to
//   take the next value. An invalid radix skips the division.
//   s_tready is high only while idle; one value is in work at a time.
// Reset: radix returns to 10, any value in work is dropped, m_tvalid clears.
// Stall: a low m_tready holds the output register and the character
//   sequencer; no character is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_crockford_text
  import i2ct_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // value
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // char_code, zero pad
  output logic [7:0]                             m_tdata,
  output logic                                   m_tlast,
  // error
  output logic                                   m_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [RADIX_BITS-1:0]             cfg_data
);

  localparam int STEPS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W = STEPS * DIV_STEP;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int ND_W  = $clog2(VALUE_BITS + 1);
  localparam int STK_W = VALUE_BITS * DIGIT_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state;
  logic [RADIX_BITS-1:0] radix;
  logic [DIV_W-1:0]      mag;
  logic [DIGIT_BITS-1:0] rem;
  logic [CNT_W-1:0]      cnt;
  logic [ND_W-1:0]       nd;
  logic                  neg;
  logic                  err;
  logic [STK_W-1:0]      stk;

  logic [DIV_W-1:0]      mag_next;
  logic [DIGIT_BITS-1:0] rem_next;
  logic [VALUE_BITS-1:0] in_val;
  logic [VALUE_BITS-1:0] in_abs;
  logic                  radix_ok;
  logic                  out_load;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = !m_tvalid || m_tready;
  assign radix_ok  = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign in_val    = s_tdata[VALUE_BITS-1:0];
  assign in_abs    = in_val[VALUE_BITS-1] ? (-in_val) : in_val;

  always_comb begin
    logic [DIGIT_BITS:0]   t;
    logic [DIGIT_BITS-1:0] r;
    logic [DIV_W-1:0]      m;
    logic                  qb;
    r = rem;
    m = mag;
    for (int j = 0; j < DIV_STEP; j++) begin
      t = {r, m[DIV_W-1]};
      if (t >= radix) begin
        t  = t - radix;
        qb = 1'b1;
      end else begin
        qb = 1'b0;
      end
      r = t[DIGIT_BITS-1:0];
      m = {m[DIV_W-2:0], qb};
    end
    rem_next = r;
    mag_next = m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      radix    <= RADIX_RESET;
      m_tvalid <= 1'b0;
      neg      <= 1'b0;
      err      <= 1'b0;
      nd       <= '0;
      cnt      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radix <= cfg_data;
      end
      if ((state == ST_EMIT) && out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            nd  <= '0;
            cnt <= '0;
            rem <= '0;
            mag <= DIV_W'(in_abs);
            if (!radix_ok) begin
              err   <= 1'b1;
              neg   <= 1'b0;
              state <= ST_EMIT;
            end else begin
              err   <= 1'b0;
              neg   <= in_val[VALUE_BITS-1];
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          mag <= mag_next;
          if (cnt == CNT_W'(STEPS - 1)) begin
            // push the finished digit, restart on the quotient
            stk <= {stk[STK_W-DIGIT_BITS-1:0], rem_next};
            nd  <= nd + ND_W'(1);
            rem <= '0;
            cnt <= '0;
            if (mag_next == '0) begin
              state <= ST_EMIT;
            end
          end else begin
            rem <= rem_next;
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (err) begin
              m_tdata <= '0;
              m_tlast <= 1'b1;
              m_tuser <= 1'b1;
              err     <= 1'b0;
              state   <= ST_IDLE;
            end else if (neg) begin
              m_tdata <= {1'b0, MINUS_CODE};
              m_tlast <= 1'b0;
              m_tuser <= 1'b0;
              neg     <= 1'b0;
            end else begin
              // pop the most significant digit
              m_tdata <= {1'b0, crockford_char(stk[DIGIT_BITS-1:0])};
              m_tlast <= (nd == ND_W'(1));
              m_tuser <= 1'b0;
              stk     <= {{DIGIT_BITS{1'b0}}, stk[STK_W-1:DIGIT_BITS]};
              nd      <= nd - ND_W'(1);
              if (nd == ND_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/i2ct_checker.sv
// ----------------------------------------------------------------------------
// Integer to Crockford text: port checker
// Watches the top-level channels for ordering and framing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_crockford_text_macros.svh"

module i2ct_checker
  import i2ct_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready
);

  `I2CT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output request changed while stalled")
  `I2CT_ASSERT_NEXT(a_one_in_work, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while a value is in work")
  `I2CT_ASSERT_SAME(a_err_frame, clk, rst, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'd0), "error request is not a lone zero")
  `I2CT_ASSERT_SAME(a_minus_first, clk, rst, m_tvalid && (m_tdata == {1'b0, MINUS_CODE}), !m_tlast && !m_tuser, "minus sign ends a text")
  `I2CT_ASSERT_SAME(a_cfg_idle, clk, rst, cfg_valid && cfg_ready, s_tready && !m_tvalid, "radix written while a value is in work")

endmodule

bind integer_to_crockford_text i2ct_checker u_i2ct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);

`default_nettype wire
